// File: hdl/pes_pkg.sv
package pes_pkg;

	localparam int POS_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int TIME_WIDTH = 24;
	localparam int T_BITS = 16;
	localparam int COLOR_WIDTH = 32;
	localparam int SIZE_WIDTH = 16;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int DIV_STEPS = TIME_WIDTH + T_BITS;
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES = DIV_STEPS / DIV_PER_STAGE;
	localparam int IN_WIDTH = 3 * TIME_WIDTH + 6 * 32;
	localparam int OUT_WIDTH = 1 + TIME_WIDTH + 6 * 32 + COLOR_WIDTH + SIZE_WIDTH;
	localparam int IN_BYTES = (IN_WIDTH + 7) / 8 * 8;
	localparam int OUT_BYTES = (OUT_WIDTH + 7) / 8 * 8;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_GRAVITY_X = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_GRAVITY_Y = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_GRAVITY_Z = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COLOR_START = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COLOR_END = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIZE_START = 3'd5;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIZE_END = 3'd6;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [T_BITS-1:0] frac_t;

	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] gz;
		logic [COLOR_WIDTH-1:0] c0;
		logic [COLOR_WIDTH-1:0] c1;
		logic [SIZE_WIDTH-1:0] s0;
		logic [SIZE_WIDTH-1:0] s1;
	} cfg_t;

	// floor(x*dt / 2^FRAC_BITS) with magnitude capped at 2^POS_WIDTH, carried two bits wider
	function automatic logic signed [POS_WIDTH+1:0] scale_prod(
		input logic signed [POS_WIDTH+TIME_WIDTH:0] prod);
		logic signed [POS_WIDTH+TIME_WIDTH:0] q;
		logic signed [POS_WIDTH+TIME_WIDTH:0] cap;
		begin
			q = prod >>> FRAC_BITS;
			cap = (POS_WIDTH+TIME_WIDTH+1)'(1) <<< POS_WIDTH;
			if (q > cap)
				scale_prod = (POS_WIDTH+2)'(cap);
			else if (q < -cap)
				scale_prod = (POS_WIDTH+2)'(-cap);
			else
				scale_prod = (POS_WIDTH+2)'(q);
		end
	endfunction

	function automatic pos_t sat_add(input pos_t a, input logic signed [POS_WIDTH+1:0] b);
		logic signed [POS_WIDTH+2:0] s;
		logic signed [POS_WIDTH+2:0] hi;
		logic signed [POS_WIDTH+2:0] lo;
		begin
			s = (POS_WIDTH+3)'(a) + (POS_WIDTH+3)'(b);
			hi = ((POS_WIDTH+3)'(1) <<< (POS_WIDTH-1)) - 1;
			lo = -hi - 1;
			if (s > hi)
				sat_add = pos_t'(hi);
			else if (s < lo)
				sat_add = pos_t'(lo);
			else
				sat_add = pos_t'(s);
		end
	endfunction

	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
		input frac_t t);
		logic [T_BITS+8:0] s;
		begin
			s = (T_BITS+9)'(a) * ((T_BITS+9)'(1) << T_BITS) - (T_BITS+9)'(a) * (T_BITS+9)'(t)
				+ (T_BITS+9)'(b) * (T_BITS+9)'(t);
			lerp8 = s[T_BITS+7:T_BITS];
		end
	endfunction

	function automatic logic [SIZE_WIDTH-1:0] lerp16(input logic [SIZE_WIDTH-1:0] a,
		input logic [SIZE_WIDTH-1:0] b, input frac_t t);
		logic [T_BITS+SIZE_WIDTH:0] s;
		begin
			s = (T_BITS+SIZE_WIDTH+1)'(a) * ((T_BITS+SIZE_WIDTH+1)'(1) << T_BITS)
				- (T_BITS+SIZE_WIDTH+1)'(a) * (T_BITS+SIZE_WIDTH+1)'(t)
				+ (T_BITS+SIZE_WIDTH+1)'(b) * (T_BITS+SIZE_WIDTH+1)'(t);
			lerp16 = s[T_BITS+SIZE_WIDTH-1:T_BITS];
		end
	endfunction

endpackage

// File: hdl/pes_cfg_regs.sv
module pes_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pes_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input logic [pes_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	output pes_pkg::cfg_t cfg
);
	import pes_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gx <= '0;
			cfg_q.gy <= '0;
			cfg_q.gz <= '0;
			cfg_q.c0 <= '1;
			cfg_q.c1 <= '0;
			cfg_q.s0 <= SIZE_WIDTH'(6554);
			cfg_q.s1 <= SIZE_WIDTH'(6554);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAVITY_X: cfg_q.gx <= cfg_data;
				REG_GRAVITY_Y: cfg_q.gy <= cfg_data;
				REG_GRAVITY_Z: cfg_q.gz <= cfg_data;
				REG_COLOR_START: cfg_q.c0 <= cfg_data;
				REG_COLOR_END: cfg_q.c1 <= cfg_data;
				REG_SIZE_START: cfg_q.s0 <= cfg_data[SIZE_WIDTH-1:0];
				REG_SIZE_END: cfg_q.s1 <= cfg_data[SIZE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/pes_divider.sv
module pes_divider (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [pes_pkg::TIME_WIDTH-1:0] age,
	input logic [pes_pkg::TIME_WIDTH-1:0] life,
	output logic [pes_pkg::T_BITS-1:0] quot
);
	import pes_pkg::*;

	logic [DIV_STEPS-1:0] num_s [DIV_STAGES+1];
	logic [TIME_WIDTH:0] rem_s [DIV_STAGES+1];
	logic [TIME_WIDTH-1:0] den_s [DIV_STAGES+1];

	assign num_s[0] = {age, T_BITS'(0)};
	assign rem_s[0] = '0;
	assign den_s[0] = life;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DIV_STEPS-1:0] num_c;
		logic [TIME_WIDTH:0] rem_c;
		always_comb begin
			num_c = num_s[g];
			rem_c = rem_s[g];
			for (int k = 0; k < DIV_PER_STAGE; k++) begin
				rem_c = {rem_c[TIME_WIDTH-1:0], num_c[DIV_STEPS-1]};
				num_c = {num_c[DIV_STEPS-2:0], 1'b0};
				if (rem_c >= {1'b0, den_s[g]}) begin
					rem_c = rem_c - {1'b0, den_s[g]};
					num_c[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				num_s[g+1] <= '0;
				rem_s[g+1] <= '0;
				den_s[g+1] <= '0;
			end else if (advance) begin
				num_s[g+1] <= num_c;
				rem_s[g+1] <= rem_c;
				den_s[g+1] <= den_s[g];
			end
		end
	end

	assign quot = num_s[DIV_STAGES][T_BITS-1:0];

endmodule

// File: hdl/particle_euler_step.sv
// One Euler step per particle, one particle per clock unless the output stalls.
// Each beat passes through 12 register stages once it is accepted: an age
// stage, ten stages of the restoring divider that forms age/lifetime (four
// quotient bits each), with four stages overlapping it for gravity*dt, the new
// velocity, velocity*dt and the new position, then an output register that also
// forms color and size. Any downstream stall freezes the whole pipe; s_tready is
// high whenever the output beat is free or being taken. The user must write gravity,
// colors and sizes via cfg only with no beat in flight; the block does not enforce it.
module particle_euler_step (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pes_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input logic [pes_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// step_time, age_in, life_span, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z
	input logic [pes_pkg::IN_BYTES-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// still_alive, age_out, new_vel_x/y/z, new_pos_x/y/z, color_now, size_now
	output logic [pes_pkg::OUT_BYTES-1:0] m_tdata
);
	import pes_pkg::*;

	localparam int LAT = DIV_STAGES + 1;

	cfg_t cfg;
	logic advance;
	logic [LAT:0] vld_q;

	time_t dt_in, age_in, life_in;
	pos_t vx_in, vy_in, vz_in, px_in, py_in, pz_in;
	assign dt_in = s_tdata[23:0];
	assign age_in = s_tdata[47:24];
	assign life_in = s_tdata[71:48];
	assign vx_in = s_tdata[103:72];
	assign vy_in = s_tdata[135:104];
	assign vz_in = s_tdata[167:136];
	assign px_in = s_tdata[199:168];
	assign py_in = s_tdata[231:200];
	assign pz_in = s_tdata[263:232];

	pes_cfg_regs u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	assign advance = !m_tvalid || m_tready;
	assign s_tready = advance;

	// stage 1: age
	time_t dt_s1, age_s1, life_s1;
	logic dead_s1;
	pos_t v_s1 [3];
	pos_t p_s1 [3];
	logic [TIME_WIDTH:0] age_sum;
	assign age_sum = {1'b0, age_in} + {1'b0, dt_in};

	always_ff @(posedge clk) begin
		if (advance) begin
			dt_s1 <= dt_in;
			age_s1 <= age_sum[TIME_WIDTH] ? '1 : age_sum[TIME_WIDTH-1:0];
			life_s1 <= life_in;
			v_s1 <= '{vx_in, vy_in, vz_in};
			p_s1 <= '{px_in, py_in, pz_in};
		end
	end
	assign dead_s1 = age_s1 >= life_s1;

	frac_t t_div;
	pes_divider u_div (.clk, .arst_n, .advance, .age(age_s1), .life(life_s1), .quot(t_div));

	// stage 2: gravity products; stage 3: new velocity; stage 4: pos products; 5: pos
	logic signed [POS_WIDTH+TIME_WIDTH:0] gp_s2 [3];
	pos_t v_s2 [3], p_s2 [3], v_s3 [3], p_s3 [3], v_s5 [3], p_s5 [3];
	logic signed [POS_WIDTH+TIME_WIDTH:0] pp_s4 [3];
	pos_t v_s4 [3], p_s4 [3];
	time_t dt_s2, dt_s3;
	logic signed [31:0] gsel [3];
	assign gsel = '{cfg.gx, cfg.gy, cfg.gz};

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				gp_s2[i] <= (POS_WIDTH+TIME_WIDTH+1)'(gsel[i])
					* (POS_WIDTH+TIME_WIDTH+1)'($signed({1'b0, dt_s1}));
				v_s3[i] <= sat_add(v_s2[i], scale_prod(gp_s2[i]));
				pp_s4[i] <= (POS_WIDTH+TIME_WIDTH+1)'(v_s3[i])
					* (POS_WIDTH+TIME_WIDTH+1)'($signed({1'b0, dt_s3}));
				v_s5[i] <= v_s4[i];
				p_s5[i] <= sat_add(p_s4[i], scale_prod(pp_s4[i]));
			end
			v_s2 <= v_s1;
			p_s2 <= p_s1;
			p_s3 <= p_s2;
			v_s4 <= v_s3;
			p_s4 <= p_s3;
			dt_s2 <= dt_s1;
			dt_s3 <= dt_s2;
		end
	end

	// carry originals, age and results alongside the divider
	time_t age_d [LAT];
	logic dead_d [LAT];
	pos_t vo_d [LAT][3];
	pos_t po_d [LAT][3];
	pos_t vn_d [LAT][3];
	pos_t pn_d [LAT][3];

	always_ff @(posedge clk) begin
		if (advance) begin
			age_d[1] <= age_s1;
			dead_d[1] <= dead_s1;
			vo_d[1] <= v_s1;
			po_d[1] <= p_s1;
			for (int k = 2; k < LAT; k++) begin
				age_d[k] <= age_d[k-1];
				dead_d[k] <= dead_d[k-1];
				vo_d[k] <= vo_d[k-1];
				po_d[k] <= po_d[k-1];
			end
			vn_d[5] <= v_s5;
			pn_d[5] <= p_s5;
			for (int k = 6; k < LAT; k++) begin
				vn_d[k] <= vn_d[k-1];
				pn_d[k] <= pn_d[k-1];
			end
		end
	end

	// final stage: color and size, select by life
	logic alive_o;
	time_t age_o;
	pos_t v_o [3], p_o [3];
	logic [COLOR_WIDTH-1:0] col_o;
	logic [SIZE_WIDTH-1:0] size_o;
	logic [COLOR_WIDTH-1:0] col_c;
	logic dead_f;
	assign dead_f = dead_d[LAT-1];

	always_comb begin
		for (int b = 0; b < 4; b++)
			col_c[8*b +: 8] = lerp8(cfg.c0[8*b +: 8], cfg.c1[8*b +: 8], t_div);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			alive_o <= !dead_f;
			age_o <= age_d[LAT-1];
			v_o <= dead_f ? vo_d[LAT-1] : vn_d[LAT-1];
			p_o <= dead_f ? po_d[LAT-1] : pn_d[LAT-1];
			col_o <= dead_f ? '0 : col_c;
			size_o <= dead_f ? '0 : lerp16(cfg.s0, cfg.s1, t_div);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (advance)
			vld_q <= {vld_q[LAT-1:0], s_tvalid};
	end

	assign m_tvalid = vld_q[LAT];
	assign m_tdata = {(OUT_BYTES-OUT_WIDTH)'(0), size_o, col_o, p_o[2], p_o[1], p_o[0],
		v_o[2], v_o[1], v_o[0], age_o, alive_o};

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("pipe stalled with empty output");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_WIDTH-1 -: SIZE_WIDTH] == '0)
		else $error("dead particle with nonzero size");
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(vld_q))
		else $error("valid bits moved during stall");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import pes_pkg::*;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
	localparam time_t TIME_MAX = '1;

	typedef struct {
		time_t dt;
		time_t age;
		time_t life;
		pos_t vel[3];
		pos_t pos[3];
	} particle_t;

	typedef struct {
		logic alive;
		time_t age;
		pos_t vel[3];
		pos_t pos[3];
		logic [COLOR_WIDTH-1:0] color;
		logic [SIZE_WIDTH-1:0] size;
	} update_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_BYTES-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_BYTES-1:0] m_tdata;

	pos_t grav[3];
	logic [COLOR_WIDTH-1:0] col_start, col_end;
	logic [SIZE_WIDTH-1:0] sz_start, sz_end;

	update_t pending_updates[$];
	int errors = 0;
	bit no_idle = 0;

	particle_euler_step uut (.*);

	always #10 clk = ~clk;

	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 15);

	function automatic longint scaled(longint x, time_t dt);
		longint q;
		q = (x * longint'(dt)) >>> FRAC_BITS;
		if (q > (64'sd1 <<< POS_WIDTH)) q = 64'sd1 <<< POS_WIDTH;
		if (q < -(64'sd1 <<< POS_WIDTH)) q = -(64'sd1 <<< POS_WIDTH);
		return q;
	endfunction

	function automatic pos_t clamp_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return pos_t'(s);
	endfunction

	function automatic longint fade(longint a, longint b, longint t);
		return (a * (65536 - t) + b * t) >>> T_BITS;
	endfunction

	function automatic update_t euler_predict(particle_t p);
		update_t r;
		longint sum, t;
		sum = longint'(p.age) + longint'(p.dt);
		r.age = (sum > longint'(TIME_MAX)) ? TIME_MAX : time_t'(sum);
		r.vel = p.vel;
		r.pos = p.pos;
		r.color = '0;
		r.size = '0;
		r.alive = !(r.age >= p.life);
		if (r.alive) begin
			for (int i = 0; i < 3; i++) begin
				r.vel[i] = clamp_add(longint'(p.vel[i]), scaled(longint'(grav[i]), p.dt));
				r.pos[i] = clamp_add(longint'(p.pos[i]), scaled(longint'(r.vel[i]), p.dt));
			end
			t = (longint'(r.age) << T_BITS) / longint'(p.life);
			for (int sh = 0; sh < 32; sh += 8)
				r.color[sh+:8] = 8'(fade(longint'(col_start[sh+:8]),
					longint'(col_end[sh+:8]), t));
			r.size = SIZE_WIDTH'(fade(longint'(sz_start), longint'(sz_end), t));
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (expected !== actual) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, expected, actual);
		end
	endtask

	always @(posedge clk) begin
		update_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_updates.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none actual %h", $time, m_tdata);
			end else begin
				want = pending_updates.pop_front();
				check_field("still_alive", 32'(want.alive), 32'(m_tdata[0]));
				check_field("age_out", 32'(want.age), 32'(m_tdata[24:1]));
				for (int i = 0; i < 3; i++) begin
					check_field($sformatf("new_vel[%0d]", i), want.vel[i], m_tdata[25+32*i+:32]);
					check_field($sformatf("new_pos[%0d]", i), want.pos[i], m_tdata[121+32*i+:32]);
				end
				check_field("color_now", want.color, m_tdata[248:217]);
				check_field("size_now", 32'(want.size), 32'(m_tdata[264:249]));
			end
		end
	end

	task automatic send_particle(particle_t p);
		update_t r;
		if (!no_idle)
			while ($urandom_range(99) < 15) begin
				s_tvalid <= 0;
				@(posedge clk);
			end
		r = euler_predict(p);
		s_tvalid <= 1;
		s_tdata <= {p.pos[2], p.pos[1], p.pos[0], p.vel[2], p.vel[1], p.vel[0],
			p.life, p.age, p.dt};
		do @(posedge clk); while (!s_tready);
		pending_updates.insert(pending_updates.size(), r);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		case (idx)
			REG_GRAVITY_X: grav[0] = val;
			REG_GRAVITY_Y: grav[1] = val;
			REG_GRAVITY_Z: grav[2] = val;
			REG_COLOR_START: col_start = val;
			REG_COLOR_END: col_end = val;
			REG_SIZE_START: sz_start = val[15:0];
			REG_SIZE_END: sz_end = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] gx, gy, gz, c0, c1, logic [15:0] s0, s1);
		drain();
		write_reg(REG_GRAVITY_X, gx);
		write_reg(REG_GRAVITY_Y, gy);
		write_reg(REG_GRAVITY_Z, gz);
		write_reg(REG_COLOR_START, c0);
		write_reg(REG_COLOR_END, c1);
		write_reg(REG_SIZE_START, {16'h0, s0});
		write_reg(REG_SIZE_END, {16'h0, s1});
	endtask

	function automatic particle_t make_particle(time_t dt, age, life, pos_t v, pos_t q);
		particle_t p;
		p.dt = dt;
		p.age = age;
		p.life = life;
		p.vel = '{v, -v, v >>> 3};
		p.pos = '{q, -q, q >>> 5};
		return p;
	endfunction

	function automatic particle_t random_particle;
		particle_t p;
		p.life = time_t'($urandom);
		p.dt = time_t'($urandom);
		p.age = time_t'($urandom);
		if ($urandom_range(9) < 8) begin
			if (p.life == 0) p.life = 1;
			p.age = time_t'($urandom_range(p.life - 1));
			p.dt = time_t'($urandom) >> $urandom_range(23);
		end
		for (int i = 0; i < 3; i++) begin
			p.vel[i] = $urandom;
			p.pos[i] = $urandom;
			if ($urandom_range(3) == 0) p.vel[i] = p.vel[i] >>> 12;
		end
		return p;
	endfunction

	task automatic test_reset_values;
		send_particle(make_particle(24'h000100, 24'h000000, 24'h010000, 32'h00010000, 0));
		send_particle(make_particle(24'h004000, 24'h008000, 24'h010000, 32'hFFFF0001, 5));
		drain();
	endtask

	task automatic test_directed;
		configure(32'h80000000, 32'h7FFFFFFF, 32'hFFFF8000,
			32'h00FF7F80, 32'hFF00807F, 16'hFFFF, 16'h0000);
		write_reg(REG_UNUSED, 32'h12345678);
		send_particle(make_particle(24'h000000, 24'h000000, TIME_MAX, 0, 0));
		send_particle(make_particle(24'h000000, 24'h000000, 24'h000001,
			32'h7FFFFFFF, 32'h80000000));
		send_particle(make_particle(TIME_MAX, TIME_MAX, TIME_MAX, 1, 1));
		send_particle(make_particle(24'h010000, 24'h020000, 24'h030000, 7, 9));
		send_particle(make_particle(24'h010000, 24'h01FFFF, 24'h030000, 7, 9));
		send_particle(make_particle(24'h000001, 24'h000000, 24'h000000,
			32'h12345678, 32'h9ABCDEF0));
		send_particle(make_particle(24'h000000, 24'h000000, 24'h000000, 0, 0));
		send_particle(make_particle(24'h7FFFFF, 24'h000000, TIME_MAX,
			32'h7FFFFFFF, 32'h7FFFFFFF));
		send_particle(make_particle(24'h7FFFFF, 24'h000000, TIME_MAX,
			32'h80000000, 32'h80000000));
		send_particle(make_particle(24'h000003, 24'h00FFFF, 24'hFFFFFF, 32'hFFFFFFFF, -3));
		send_particle(make_particle(24'h000001, 24'hFFFFFD, TIME_MAX, 32'h00000001, 0));
		send_particle(make_particle(24'h800000, 24'h7FFFFE, TIME_MAX, 32'h00000100, 0));
		send_particle(make_particle(24'h000010, 24'hFFFFEE, TIME_MAX, 32'h55555555, 3));
		configure(0, 0, 0, 0, 32'hFFFFFFFF, 16'h0000, 16'hFFFF);
		send_particle(make_particle(24'h000001, 24'h000001, 24'h000003, 32'hAAAAAAAA, 1));
		send_particle(make_particle(24'h000001, 24'hFFFFFD, TIME_MAX, 32'h7FFFFFFF, 1));
		send_particle(make_particle(24'h000000, 24'h7FFFFF, 24'h800000, -1, -1));
		drain();
	endtask

	task automatic test_random;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				configure(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
					32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 16'hFFFF);
			else
				configure($urandom >> $urandom_range(31), $urandom, -($urandom >> 8),
					$urandom, $urandom, 16'($urandom), 16'($urandom));
			no_idle = (phase == 2);
			for (int n = 0; n < 170; n++)
				send_particle(random_particle());
			no_idle = 0;
		end
		drain();
	endtask

	initial begin
		grav = '{0, 0, 0};
		col_start = 32'hFFFFFFFF;
		col_end = 0;
		sz_start = 16'd6554;
		sz_end = 16'd6554;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
